// ===== src/drhs_pkg.sv =====
// drhs_pkg: widths, types and helpers shared by the DC-removed 8x8 Hadamard SATD block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
package drhs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int IN_W        = 16;
    localparam int N           = 8;
    localparam int ROW_W       = 3;
    localparam int H_W         = SAMPLE_BITS + 4;
    localparam int ACC_W       = SAMPLE_BITS + 7;
    localparam int ABS_W       = SAMPLE_BITS + 6;
    localparam int PAIR_W      = ABS_W + 1;
    localparam int LSUM_W      = ABS_W + 3;
    localparam int MPAIR_W     = LSUM_W + 1;
    localparam int QUAD_W      = LSUM_W + 2;
    localparam int TOT_W       = LSUM_W + 3;
    localparam int SATD_W      = 26;
    localparam int RND_ADD     = 2;
    localparam int RND_SHIFT   = 2;

    localparam logic [ROW_W-1:0] FIRST_ROW = '0;
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(N - 1);

    typedef logic [IN_W-1:0]          t_sample;
    typedef logic signed [H_W-1:0]    t_h;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [LSUM_W-1:0]        t_lsum;

    function automatic logic [ABS_W-1:0] abs_acc(input t_acc x);
        t_acc m;
        m = x[ACC_W-1] ? -x : x;
        return m[ABS_W-1:0];
    endfunction

endpackage

// ===== src/dc_removed_hadamard_satd_8x8.sv =====
// dc_removed_hadamard_satd_8x8: top level; row counter, row butterfly, eight column lanes
// and the merge stage. Depends on drhs_pkg, drhs_row_bfly, drhs_col_lane, drhs_merge.
//
// Usage:
//   Input channel (i_valid / o_stall, payload i_px0..i_px7): one beat carries one row of
//   eight samples; the block counts rows itself, eight beats make one 8x8 block.
//   Output channel (o_valid / i_stall, payload o_satd): one beat per block, after its
//   eighth row: (sum of |coef| over the 63 non-DC Hadamard coefficients + 2) >> 2.
//   Throughput: one row per cycle while o_stall is low; blocks follow back to back when the receiver keeps up.
//   Pipeline: 7 register stages lie between the eighth row and the result beat
//   (butterfly, column accumulate, abs and pair add, lane sum, two merge adds, round).
//   Stall: the result waits in the output register; rows 0..6 of the next block keep
//   flowing, and only its eighth row is held off (o_stall) until that result is taken.
//   Reset: synchronous, active low; row count returns to zero, nothing is in flight.
//   Accumulators need no clearing: the first row of each block overwrites them.
`timescale 1ns / 1ps
module dc_removed_hadamard_satd_8x8 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  drhs_pkg::t_sample           i_px0,
    input  drhs_pkg::t_sample           i_px1,
    input  drhs_pkg::t_sample           i_px2,
    input  drhs_pkg::t_sample           i_px3,
    input  drhs_pkg::t_sample           i_px4,
    input  drhs_pkg::t_sample           i_px5,
    input  drhs_pkg::t_sample           i_px6,
    input  drhs_pkg::t_sample           i_px7,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [drhs_pkg::SATD_W-1:0] o_satd
);
    import drhs_pkg::*;

    logic              r_busy;
    logic [ROW_W-1:0]  r_row;
    logic              w_acc;
    logic              w_out_acc;
    t_sample           w_px [N];
    logic              w_bv;
    logic [ROW_W-1:0]  w_brow;
    t_h                w_h  [N];
    logic [N-1:0]      w_lv;
    t_lsum             w_ls [N];

    assign w_px[0] = i_px0;
    assign w_px[1] = i_px1;
    assign w_px[2] = i_px2;
    assign w_px[3] = i_px3;
    assign w_px[4] = i_px4;
    assign w_px[5] = i_px5;
    assign w_px[6] = i_px6;
    assign w_px[7] = i_px7;

    assign o_stall   = r_busy && (r_row == LAST_ROW);
    assign w_acc     = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= FIRST_ROW;
            r_busy <= 1'b0;
        end else begin
            if (w_acc) begin
                r_row <= r_row + 1'b1;
            end
            if (w_acc && r_row == LAST_ROW) begin
                r_busy <= 1'b1;
            end else if (w_out_acc) begin
                r_busy <= 1'b0;
            end
        end
    end

    drhs_row_bfly u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_row   (r_row),
        .i_px    (w_px),
        .o_valid (w_bv),
        .o_row   (w_brow),
        .o_h     (w_h)
    );

    for (genvar c = 0; c < N; c++) begin : g_lane
        drhs_col_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_bv),
            .i_row     (w_brow),
            .i_h       (w_h[c]),
            .i_skip_dc (c == 0),
            .o_valid   (w_lv[c]),
            .o_sum     (w_ls[c])
        );
    end

    drhs_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (&w_lv),
        .i_sum   (w_ls),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_satd  (o_satd)
    );

    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_busy)
        else $error("result beat shown with no block in flight");

    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_row == LAST_ROW) |=> (r_busy && r_row == FIRST_ROW))
        else $error("last row did not open a result slot");

    a_out_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |=> !r_busy)
        else $error("result slot not freed after output beat");

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lv == '0) || (w_lv == '1))
        else $error("column lanes out of step");

endmodule

// ===== src/drhs_row_bfly.sv =====
// drhs_row_bfly: registered 8-point natural-order Hadamard butterfly on one row beat.
// Depends on drhs_pkg.
`timescale 1ns / 1ps
module drhs_row_bfly (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [drhs_pkg::ROW_W-1:0] i_row,
    input  drhs_pkg::t_sample          i_px [drhs_pkg::N],
    output logic                       o_valid,
    output logic [drhs_pkg::ROW_W-1:0] o_row,
    output drhs_pkg::t_h               o_h [drhs_pkg::N]
);
    import drhs_pkg::*;

    t_h                w_s0 [N];
    t_h                w_s1 [N];
    t_h                w_s2 [N];
    t_h                n_h  [N];
    logic              r_valid;
    logic [ROW_W-1:0]  r_row;
    t_h                r_h  [N];

    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_s0[k] = t_h'({{(H_W - SAMPLE_BITS){1'b0}}, i_px[k][SAMPLE_BITS-1:0]});
        end
        for (int k = 0; k < 4; k++) begin
            w_s1[k]     = w_s0[k] + w_s0[k + 4];
            w_s1[k + 4] = w_s0[k] - w_s0[k + 4];
        end
        for (int k = 0; k < N; k += 4) begin
            w_s2[k]     = w_s1[k]     + w_s1[k + 2];
            w_s2[k + 1] = w_s1[k + 1] + w_s1[k + 3];
            w_s2[k + 2] = w_s1[k]     - w_s1[k + 2];
            w_s2[k + 3] = w_s1[k + 1] - w_s1[k + 3];
        end
        for (int k = 0; k < N; k += 2) begin
            n_h[k]     = w_s2[k] + w_s2[k + 1];
            n_h[k + 1] = w_s2[k] - w_s2[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_row <= i_row;
            r_h   <= n_h;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;
    assign o_h     = r_h;

endmodule

// ===== src/drhs_col_lane.sv =====
// drhs_col_lane: a column lane; accumulates its column's vertical transform and, after
// the last row, reduces |coef| of its 8 entries bar a skipped DC. Depends on drhs_pkg.
`timescale 1ns / 1ps
module drhs_col_lane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [drhs_pkg::ROW_W-1:0] i_row,
    input  drhs_pkg::t_h               i_h,
    input  logic                       i_skip_dc,
    output logic                       o_valid,
    output drhs_pkg::t_lsum            o_sum
);
    import drhs_pkg::*;

    t_acc               r_acc  [N];
    t_acc               n_acc  [N];
    logic               r_fin;
    logic [PAIR_W-1:0]  r_pair [4];
    logic [PAIR_W-1:0]  n_pair [4];
    logic               r_pv;
    t_lsum              r_sum;
    logic               r_sv;

    always_comb begin
        t_acc             base;
        t_acc             hx;
        logic [ABS_W-1:0] a0;
        logic [ABS_W-1:0] a1;
        hx = ACC_W'(i_h);
        for (int v = 0; v < N; v++) begin
            base = (i_row == FIRST_ROW) ? '0 : r_acc[v];
            n_acc[v] = (^(ROW_W'(v) & i_row)) ? base - hx : base + hx;
        end
        for (int k = 0; k < 4; k++) begin
            a0 = (k == 0 && i_skip_dc) ? '0 : abs_acc(r_acc[2 * k]);
            a1 = abs_acc(r_acc[2 * k + 1]);
            n_pair[k] = PAIR_W'(a0) + PAIR_W'(a1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= 1'b0;
            r_pv  <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            r_fin <= i_valid && (i_row == LAST_ROW);
            r_pv  <= r_fin;
            r_sv  <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_acc <= n_acc;
        end
        if (r_fin) begin
            r_pair <= n_pair;
        end
        if (r_pv) begin
            r_sum <= LSUM_W'(r_pair[0]) + LSUM_W'(r_pair[1])
                   + LSUM_W'(r_pair[2]) + LSUM_W'(r_pair[3]);
        end
    end

    assign o_valid = r_sv;
    assign o_sum   = r_sum;

endmodule

// ===== src/drhs_merge.sv =====
// drhs_merge: adds the eight lane sums in a registered tree, rounds to a quarter and
// holds the result beat for the receiver. Depends on drhs_pkg.
`timescale 1ns / 1ps
module drhs_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  drhs_pkg::t_lsum             i_sum [drhs_pkg::N],
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [drhs_pkg::SATD_W-1:0] o_satd
);
    import drhs_pkg::*;

    logic [MPAIR_W-1:0] r_m [4];
    logic               r_mv;
    logic [QUAD_W-1:0]  r_q [2];
    logic               r_qv;
    logic [TOT_W:0]     w_tot;
    logic [SATD_W-1:0]  r_satd;
    logic               r_out_valid;

    assign w_tot = (TOT_W + 1)'(r_q[0]) + (TOT_W + 1)'(r_q[1]) + (TOT_W + 1)'(RND_ADD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv        <= 1'b0;
            r_qv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mv <= i_valid;
            r_qv <= r_mv;
            if (r_qv) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int k = 0; k < 4; k++) begin
                r_m[k] <= MPAIR_W'(i_sum[2 * k]) + MPAIR_W'(i_sum[2 * k + 1]);
            end
        end
        if (r_mv) begin
            r_q[0] <= QUAD_W'(r_m[0]) + QUAD_W'(r_m[1]);
            r_q[1] <= QUAD_W'(r_m[2]) + QUAD_W'(r_m[3]);
        end
        if (r_qv) begin
            r_satd <= SATD_W'(w_tot >> RND_SHIFT);
        end
    end

    assign o_valid = r_out_valid;
    assign o_satd  = r_satd;

    // only one result may be in flight: the output slot is free when the tree finishes
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qv |-> !r_out_valid)
        else $error("merge result arrived while output beat still held");

endmodule
